### design/bqc_pkg.sv
package bqc_pkg;

  localparam int unsigned DEF_MAX_CHANNELS = 2;
  localparam int unsigned DEF_MAX_STAGES   = 8;

  localparam int unsigned SMP_W  = 24;
  localparam int unsigned COEF_W = 32;
  localparam int unsigned HIST_W = 48;
  // product of sample and coefficient after the shift by 11
  localparam int unsigned PROD_W = SMP_W + COEF_W - 11;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh1000_0000;

  localparam logic [3:0] STAGE_COUNT_RST = 4'd0;
  localparam logic [1:0] CHANNELS_RST    = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_STAGE_COUNT = 1'b0;
  localparam logic REG_CHANNELS    = 1'b1;

  typedef enum logic [1:0] {
    FUNC_FILTER = 2'd0,
    FUNC_COEF   = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_HOLD
  } seq_st_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ROUND,
    PH_FB,
    PH_UPD
  } cell_ph_t;

  // sample handed from cell to cell
  typedef struct packed {
    logic                    vld;
    logic                    flt;
    logic                    ch;
    logic signed [SMP_W-1:0] x;
  } link_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                     coef_we;
    logic [2:0]               coef_stage;
    logic [2:0]               coef_sel;
    logic signed [COEF_W-1:0] coef_value;
    logic                     hist_clr;
  } cell_ctl_t;

  // sample times coefficient, floor shift by 11
  function automatic logic signed [PROD_W-1:0] mul_q(input logic signed [SMP_W-1:0] x,
                                                      input logic signed [COEF_W-1:0] c);
    logic signed [SMP_W+COEF_W-1:0] p;
    p = x * c;
    return p[SMP_W+COEF_W-1:11];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [31:0] v);
    logic signed [SMP_W-1:0] r;
    if ((&v[31:SMP_W-1]) || !(|v[31:SMP_W-1])) begin
      r = v[SMP_W-1:0];
    end else if (v[31]) begin
      r = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SMP_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [HIST_W+1:0] v);
    logic signed [HIST_W-1:0] r;
    if ((&v[HIST_W+1:HIST_W-1]) || !(|v[HIST_W+1:HIST_W-1])) begin
      r = v[HIST_W-1:0];
    end else if (v[HIST_W+1]) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### design/bqc_cell.sv
module bqc_cell #(
  parameter int unsigned MAX_CHANNELS = bqc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned IDX          = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              stage_en,
  input  bqc_pkg::cell_ctl_t ctl,
  input  bqc_pkg::link_t    link_in,
  output bqc_pkg::link_t    link_out
);

  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  bqc_pkg::cell_ph_t ph_r, ph_nxt;
  bqc_pkg::link_t    link_out_r, link_nxt;

  logic signed [bqc_pkg::COEF_W-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [bqc_pkg::HIST_W-1:0] h0_r [MAX_CHANNELS];
  logic signed [bqc_pkg::HIST_W-1:0] h1_r [MAX_CHANNELS];

  logic signed [bqc_pkg::PROD_W-1:0] p0_r, p1_r, p2_r, q1_r, q2_r;
  logic signed [bqc_pkg::SMP_W-1:0]  y_r;
  logic                              ch_r;
  logic [CHW-1:0]                    ch_idx;

  logic run, cap_x, hist_we;
  logic signed [bqc_pkg::HIST_W:0]   acc;
  logic signed [bqc_pkg::HIST_W+1:0] n1;
  logic signed [bqc_pkg::HIST_W-1:0] n2;

  assign run    = link_in.flt && stage_en;
  assign ch_idx = CHW'(ch_r);

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      bqc_pkg::PH_IDLE:  if (link_in.vld && run) ph_nxt = bqc_pkg::PH_ROUND;
      bqc_pkg::PH_ROUND: ph_nxt = bqc_pkg::PH_FB;
      bqc_pkg::PH_FB:    ph_nxt = bqc_pkg::PH_UPD;
      bqc_pkg::PH_UPD:   ph_nxt = bqc_pkg::PH_IDLE;
      default:           ph_nxt = bqc_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    link_nxt     = link_out_r;
    link_nxt.vld = 1'b0;
    cap_x        = 1'b0;
    hist_we      = 1'b0;
    unique case (ph_r)
      bqc_pkg::PH_IDLE: begin
        cap_x = link_in.vld && run;
        if (link_in.vld && !run) link_nxt = link_in;
      end
      bqc_pkg::PH_UPD: begin
        hist_we      = 1'b1;
        link_nxt.vld = 1'b1;
        link_nxt.flt = 1'b1;
        link_nxt.ch  = ch_r;
        link_nxt.x   = y_r;
      end
      default: ;
    endcase
  end

  // y in Q8.40, round half up to Q1.23
  assign acc = (bqc_pkg::HIST_W+1)'(p0_r) + (bqc_pkg::HIST_W+1)'(h0_r[ch_idx])
             + 49'sd65536;
  assign n1  = (bqc_pkg::HIST_W+2)'(p1_r) - (bqc_pkg::HIST_W+2)'(q1_r)
             + (bqc_pkg::HIST_W+2)'(h1_r[ch_idx]);
  // cannot leave the history range
  assign n2  = bqc_pkg::HIST_W'(p2_r) - bqc_pkg::HIST_W'(q2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r           <= bqc_pkg::PH_IDLE;
      link_out_r.vld <= 1'b0;
    end else begin
      ph_r       <= ph_nxt;
      link_out_r <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_x) begin
      p0_r <= bqc_pkg::mul_q(link_in.x, b0_r);
      p1_r <= bqc_pkg::mul_q(link_in.x, b1_r);
      p2_r <= bqc_pkg::mul_q(link_in.x, b2_r);
      ch_r <= link_in.ch;
    end
    if (ph_r == bqc_pkg::PH_ROUND) y_r <= bqc_pkg::sat_smp(acc[bqc_pkg::HIST_W:17]);
    if (ph_r == bqc_pkg::PH_FB) begin
      q1_r <= bqc_pkg::mul_q(y_r, a1_r);
      q2_r <= bqc_pkg::mul_q(y_r, a2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= bqc_pkg::COEF_ONE;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (ctl.coef_we && (int'(ctl.coef_stage) == IDX)) begin
      unique case (ctl.coef_sel)
        bqc_pkg::COEF_B0: b0_r <= ctl.coef_value;
        bqc_pkg::COEF_B1: b1_r <= ctl.coef_value;
        bqc_pkg::COEF_B2: b2_r <= ctl.coef_value;
        bqc_pkg::COEF_A1: a1_r <= ctl.coef_value;
        bqc_pkg::COEF_A2: a2_r <= ctl.coef_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.hist_clr) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        h0_r[i] <= '0;
        h1_r[i] <= '0;
      end
    end else if (hist_we) begin
      h0_r[ch_idx] <= bqc_pkg::sat_hist(n1);
      h1_r[ch_idx] <= n2;
    end
  end

  assign link_out = link_out_r;

endmodule

### design/biquad_cascade_filter.sv
// channel | handshake                       | payload
// in      | in_valid / in_stall             | in_func, in_channel, in_sample_in,
//         |                                 | in_coef_stage, in_coef_select, in_coef_value
// out     | out_valid / out_stall           | out_sample_out
// cfg     | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
// a sample request walks the row of section cells; an active cell steps through
// x products, round y, feedback products and history update, a skipped cell only registers it
// the block takes no new sample request until the last result has reached the output register;
// writes and clears do not stall the input and return nothing
// reset: synchronous, active low; coefficients go to identity, histories to zero
// out_stall holds the result; a second result waits in a holding register and stalls the input
module biquad_cascade_filter #(
  parameter int unsigned MAX_CHANNELS = bqc_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned MAX_STAGES   = bqc_pkg::DEF_MAX_STAGES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_func,
  input  logic                               in_channel,
  input  logic signed [bqc_pkg::SMP_W-1:0]   in_sample_in,
  input  logic [2:0]                         in_coef_stage,
  input  logic [2:0]                         in_coef_select,
  input  logic signed [bqc_pkg::COEF_W-1:0]  in_coef_value,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bqc_pkg::SMP_W-1:0]   out_sample_out,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  bqc_pkg::seq_st_t   st_r, st_nxt;
  bqc_pkg::link_t     link0_r;
  bqc_pkg::link_t     links [MAX_STAGES+1];
  bqc_pkg::cell_ctl_t ctl;

  logic [3:0] stage_count_r;
  logic [1:0] channels_r;

  logic                            out_valid_r;
  logic signed [bqc_pkg::SMP_W-1:0] out_sample_r, pend_r;
  logic [MAX_STAGES-1:0]           stage_en;

  logic in_accept, is_filter, out_free, chain_done, cfg_we, ch_filtered;

  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite && pready;
  assign in_accept = in_valid && !in_stall;
  assign is_filter = in_func == bqc_pkg::FUNC_FILTER;
  assign out_free  = !out_valid_r || !out_stall;
  assign chain_done = links[MAX_STAGES].vld;

  // channel filtered when below the in-use count and the built channel count
  assign ch_filtered = ({1'b0, in_channel} < channels_r) && (int'(in_channel) < MAX_CHANNELS);

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_count_r <= bqc_pkg::STAGE_COUNT_RST;
      channels_r    <= bqc_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        bqc_pkg::REG_STAGE_COUNT: stage_count_r <= pwdata[3:0];
        bqc_pkg::REG_CHANNELS:    channels_r    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bqc_pkg::REG_STAGE_COUNT: prdata = {28'd0, stage_count_r};
      bqc_pkg::REG_CHANNELS:    prdata = {30'd0, channels_r};
      default:                  prdata = '0;
    endcase
  end

  // a cell applies its section when it lies below the stage count;
  // counts above MAX_STAGES thus saturate by themselves
  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_en
    assign stage_en[i] = i < int'(stage_count_r);
  end

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bqc_pkg::SEQ_IDLE: if (in_accept && is_filter) st_nxt = bqc_pkg::SEQ_RUN;
      bqc_pkg::SEQ_RUN:  if (chain_done) st_nxt = out_free ? bqc_pkg::SEQ_IDLE
                                                           : bqc_pkg::SEQ_HOLD;
      bqc_pkg::SEQ_HOLD: if (out_free) st_nxt = bqc_pkg::SEQ_IDLE;
      default:           st_nxt = bqc_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = st_r != bqc_pkg::SEQ_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= bqc_pkg::SEQ_IDLE;
    else        st_r <= st_nxt;
  end

  // broadcast coefficient writes and clears to the row
  always_comb begin
    ctl.coef_we    = in_accept && (in_func == bqc_pkg::FUNC_COEF);
    ctl.coef_stage = in_coef_stage;
    ctl.coef_sel   = in_coef_select;
    ctl.coef_value = in_coef_value;
    ctl.hist_clr   = in_accept && (in_func == bqc_pkg::FUNC_CLEAR);
  end

  // head of the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link0_r.vld <= 1'b0;
    end else begin
      link0_r.vld <= in_accept && is_filter;
      link0_r.flt <= ch_filtered;
      link0_r.ch  <= in_channel;
      link0_r.x   <= in_sample_in;
    end
  end

  assign links[0] = link0_r;

  for (genvar i = 0; i < MAX_STAGES; i++) begin : g_cell
    bqc_cell #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .IDX          (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .stage_en (stage_en[i]),
      .ctl      (ctl),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  // output register with one holding slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      if (st_r == bqc_pkg::SEQ_HOLD) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= pend_r;
      end else if (chain_done) begin
        out_valid_r  <= 1'b1;
        out_sample_r <= links[MAX_STAGES].x;
      end else begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_free && chain_done) pend_r <= links[MAX_STAGES].x;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

### design/bqc_chk.sv
module bqc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_sample_out,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("result changed while stalled");

  // a sample request occupies the row and cannot finish at once
  a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func == bqc_pkg::FUNC_FILTER)
    |=> in_stall && !$rose(out_valid))
    else $error("sample request did not occupy the row");

  // other requests do not stall the input
  a_other_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_func != bqc_pkg::FUNC_FILTER) |=> !in_stall)
    else $error("non-sample request stalled the input");

  // register write reads back
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready
    |=> (paddr[2] != $past(paddr[2]))
        || (paddr[2] ? (prdata == {30'd0, $past(pwdata[1:0])})
                     : (prdata == {28'd0, $past(pwdata[3:0])})))
    else $error("register read back mismatch");

endmodule

bind biquad_cascade_filter bqc_chk u_bqc_chk (.*);

### dv/tb_biquad_cascade_filter.sv
module tb_biquad_cascade_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import bqc_pkg::*;

  localparam int unsigned MAX_CH   = DEF_MAX_CHANNELS;
  localparam int unsigned MAX_ST   = DEF_MAX_STAGES;
  localparam int unsigned NUM_COEF = 5;

  // func code the block has no use for
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ADDR_STAGES   = {REG_STAGE_COUNT, 2'b00};
  localparam logic [2:0] ADDR_CHANNELS = {REG_CHANNELS, 2'b00};

  localparam logic [SMP_W-1:0] SMP_MAXV = 24'h7F_FFFF;
  localparam logic [SMP_W-1:0] SMP_MINV = 24'h80_0000;

  localparam longint SMP_HI  = 64'sh7F_FFFF;
  localparam longint SMP_LO  = -SMP_HI - 1;
  localparam longint HIST_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint HIST_LO = -HIST_HI - 1;

  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  localparam int IDLE_PCT       = 35;
  // worst case row latency plus a margin
  localparam int DRAIN_CYCLES   = 2 + 3 * MAX_ST + MAX_ST + 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1450;
  localparam int NUM_PHASES     = 7;
  localparam int NUM_DIRECTED   = 27;

  // one request on the input channel
  typedef struct packed {
    logic [1:0]        func;
    logic              channel;
    logic [SMP_W-1:0]  smp;
    logic [2:0]        stage;
    logic [2:0]        sel;
    logic [COEF_W-1:0] cval;
  } request_t;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  // one line of the directed table: a register write or a request
  typedef struct packed {
    row_kind_t        kind;
    logic [2:0]       addr;
    logic [31:0]      wdata;
    request_t         req;
    bit               typed;
    logic [SMP_W-1:0] out_val;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = '0;
  logic              in_channel = 1'b0;
  logic [SMP_W-1:0]  in_sample_in = '0;
  logic [2:0]        in_coef_stage = '0;
  logic [2:0]        in_coef_select = '0;
  logic [COEF_W-1:0] in_coef_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SMP_W-1:0]  out_sample_out;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the block: coefficients, histories and the two registers
  logic signed [COEF_W-1:0] coef_words [MAX_ST][NUM_COEF];
  logic signed [HIST_W-1:0] hist_words [MAX_ST][MAX_CH][2];
  logic [3:0]               stage_cfg;
  logic [1:0]               chan_cfg;

  // filtered samples still owed by the block, oldest first
  logic [SMP_W-1:0] pending_samples [$];

  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;
  plan_row_t directed_plan [NUM_DIRECTED];

  biquad_cascade_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_channel     (in_channel),
    .in_sample_in   (in_sample_in),
    .in_coef_stage  (in_coef_stage),
    .in_coef_select (in_coef_select),
    .in_coef_value  (in_coef_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------------

  function automatic void clear_histories();
    foreach (hist_words[s, c, w]) hist_words[s][c][w] = '0;
  endfunction

  function automatic void reset_shadow();
    foreach (coef_words[s, k]) coef_words[s][k] = (k == COEF_B0) ? COEF_ONE : '0;
    clear_histories();
    stage_cfg = STAGE_COUNT_RST;
    chan_cfg  = CHANNELS_RST;
  endfunction

  // Q1.23 times Q4.28, floored down to Q5.40
  function automatic longint scaled_mul(input longint smp, input longint cf);
    return (smp * cf) >>> 11;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // applies one request to the shadow; returns 1 when it yields a sample
  function automatic bit shadow_request(input request_t r, output logic [SMP_W-1:0] y_out);
    longint      x, y, acc, n1, n2;
    int unsigned sections, live_ch;
    bit          produced;
    produced = 1'b0;
    y_out = '0;
    case (r.func)
      FUNC_COEF: begin
        // select codes above a2 write nothing
        if (r.stage < MAX_ST && r.sel <= COEF_A2) coef_words[r.stage][r.sel] = r.cval;
      end
      FUNC_CLEAR: begin
        clear_histories();
      end
      FUNC_FILTER: begin
        x = longint'($signed(r.smp));
        sections = (stage_cfg > MAX_ST) ? MAX_ST : stage_cfg;
        live_ch  = (chan_cfg > MAX_CH) ? MAX_CH : chan_cfg;
        // channels outside the live range leave the sample and histories alone
        if (r.channel < live_ch) begin
          for (int s = 0; s < sections; s++) begin
            acc = scaled_mul(x, coef_words[s][COEF_B0]) + hist_words[s][r.channel][0];
            // round half up from Q8.40 to Q1.23, then saturate
            y = clamp((acc + 64'sd65536) >>> 17, SMP_LO, SMP_HI);
            n1 = scaled_mul(x, coef_words[s][COEF_B1]) - scaled_mul(y, coef_words[s][COEF_A1])
                 + hist_words[s][r.channel][1];
            n2 = scaled_mul(x, coef_words[s][COEF_B2]) - scaled_mul(y, coef_words[s][COEF_A2]);
            hist_words[s][r.channel][0] = HIST_W'(clamp(n1, HIST_LO, HIST_HI));
            hist_words[s][r.channel][1] = HIST_W'(clamp(n2, HIST_LO, HIST_HI));
            x = y;
          end
        end
        y_out = x[SMP_W-1:0];
        produced = 1'b1;
      end
      default: begin
      end
    endcase
    return produced;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic plan_row_t req_row(input logic [1:0] func, input logic ch,
                                        input logic [SMP_W-1:0] smp, input logic [2:0] stage,
                                        input logic [2:0] sel, input logic [COEF_W-1:0] cval,
                                        input bit typed, input logic [SMP_W-1:0] out_val);
    plan_row_t row;
    row = '0;
    row.kind        = ROW_REQ;
    row.req.func    = func;
    row.req.channel = ch;
    row.req.smp     = smp;
    row.req.stage   = stage;
    row.req.sel     = sel;
    row.req.cval    = cval;
    row.typed       = typed;
    row.out_val     = out_val;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(input logic [2:0] addr, input logic [31:0] wdata);
    plan_row_t row;
    row = '0;
    row.kind  = ROW_CFG;
    row.addr  = addr;
    row.wdata = wdata;
    return row;
  endfunction

  // mostly tame coefficients so the filters do something useful, now and then any word
  function automatic logic [COEF_W-1:0] pick_coef(input logic [2:0] sel);
    if ($urandom_range(7) == 0) return $urandom;
    if (sel == COEF_A1) return $urandom_range(32'h2000_0000) - 32'h1000_0000;
    return $urandom_range(32'h1000_0000) - 32'h0800_0000;
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(11))
      0: return SMP_MAXV;
      1: return SMP_MINV;
      2: return '0;
      3: return '1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    r.func    = FUNC_FILTER;
    r.channel = 1'($urandom_range(1));
    r.smp     = pick_sample();
    r.stage   = 3'($urandom_range(7));
    r.sel     = ($urandom_range(4) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    r.cval    = pick_coef(r.sel);
    pick = $urandom_range(99);
    if (pick >= 96) begin
      r.func = FUNC_UNUSED;
    end else if (pick >= 92) begin
      r.func = FUNC_CLEAR;
    end else if (pick >= 80) begin
      r.func = FUNC_COEF;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input channel driver: called just after a falling edge, returns after the
  // falling edge that follows acceptance with in_valid left as it was
  // ---------------------------------------------------------------------------
  task automatic send_request(input request_t r, input bit typed,
                              input logic [SMP_W-1:0] typed_out);
    logic [SMP_W-1:0] y;
    bit               produced;
    // random gaps between requests
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= r.func;
    in_channel     <= r.channel;
    in_sample_in   <= r.smp;
    in_coef_stage  <= r.stage;
    in_coef_select <= r.sel;
    in_coef_value  <= r.cval;
    // payload holds while stalled
    @(posedge clk);
    while (in_stall) @(posedge clk);
    produced = shadow_request(r, y);
    if (produced) pending_samples.push_back(typed ? typed_out : y);
    @(negedge clk);
  endtask

  // register write with read-back; only done once the block has gone quiet
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] readback, want;
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    // coefficient writes and clears return nothing, so give the row time to empty
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_STAGES) begin
      stage_cfg = data[3:0];
      want = {28'd0, data[3:0]};
    end else begin
      chan_cfg = data[1:0];
      want = {30'd0, data[1:0]};
    end
    if (readback !== want) begin
      mismatches++;
      $display("%0t: register at %0d expected %h, got %h", $time, addr, want, readback);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, check against the oldest pending sample
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    logic [SMP_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        mismatches++;
        $display("%0t: sample_out %h with nothing pending", $time, out_sample_out);
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_out !== want) begin
          mismatches++;
          $display("%0t: sample_out expected %h, got %h", $time, want, out_sample_out);
        end
      end
    end
  end

  // watchdog on cycles with no request, result or register access going through
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int       per_phase;
    request_t r;
    logic [3:0] phase_stages [NUM_PHASES];
    logic [1:0] phase_chans  [NUM_PHASES];

    reset_shadow();
    per_phase = RANDOM_ITEMS / NUM_PHASES;
    // last phase draws its setting at random
    phase_stages = '{4'd8, 4'd1, 4'd4, 4'd0, 4'd15, 4'd2, 4'($urandom_range(15))};
    phase_chans  = '{2'd2, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0, 2'($urandom_range(3))};

    directed_plan = '{
      // reset state: no sections, samples pass through
      req_row(FUNC_FILTER, 1'b0, SMP_MAXV, 3'd0, COEF_B0, 32'd0, TYPED, SMP_MAXV),
      req_row(FUNC_FILTER, 1'b1, SMP_MINV, 3'd7, COEF_A2, '1, TYPED, SMP_MINV),
      req_row(FUNC_UNUSED, 1'b1, '1, 3'd7, 3'd7, '1, PREDICTED, '0),
      cfg_row(ADDR_STAGES, 32'd8),
      // coefficient selects out of range must not land anywhere
      req_row(FUNC_COEF, 1'b0, '0, 3'd7, 3'd7, '1, PREDICTED, '0),
      req_row(FUNC_COEF, 1'b1, '0, 3'd3, 3'd5, 32'h7FFF_FFFF, PREDICTED, '0),
      // identity sections all the way down
      req_row(FUNC_FILTER, 1'b0, SMP_MAXV, 3'd0, COEF_B0, 32'd0, TYPED, SMP_MAXV),
      req_row(FUNC_FILTER, 1'b1, SMP_MINV, 3'd0, COEF_B0, 32'd0, TYPED, SMP_MINV),
      // stage count above the section count saturates
      cfg_row(ADDR_STAGES, 32'd15),
      req_row(FUNC_FILTER, 1'b0, 24'd1, 3'd0, COEF_B0, 32'd0, TYPED, 24'd1),
      // coefficient extremes on the first section, a2 on the last
      req_row(FUNC_COEF, 1'b0, '0, 3'd0, COEF_B0, 32'h7FFF_FFFF, PREDICTED, '0),
      req_row(FUNC_COEF, 1'b0, '0, 3'd0, COEF_B1, 32'h8000_0000, PREDICTED, '0),
      req_row(FUNC_COEF, 1'b0, '0, 3'd0, COEF_B2, 32'h0800_0000, PREDICTED, '0),
      req_row(FUNC_COEF, 1'b0, '0, 3'd0, COEF_A1, 32'hE000_0000, PREDICTED, '0),
      req_row(FUNC_COEF, 1'b0, '0, 3'd7, COEF_A2, 32'h0400_0000, PREDICTED, '0),
      req_row(FUNC_FILTER, 1'b0, SMP_MAXV, 3'd0, COEF_B0, 32'd0, PREDICTED, '0),
      req_row(FUNC_FILTER, 1'b1, SMP_MINV, 3'd0, COEF_B0, 32'd0, PREDICTED, '0),
      req_row(FUNC_FILTER, 1'b0, '0, 3'd0, COEF_B0, 32'd0, PREDICTED, '0),
      // after a clear, zero in gives zero out
      req_row(FUNC_CLEAR, 1'b0, '0, 3'd0, COEF_B0, 32'd0, PREDICTED, '0),
      req_row(FUNC_FILTER, 1'b0, '0, 3'd0, COEF_B0, 32'd0, TYPED, '0),
      // no live channels: pass through
      cfg_row(ADDR_CHANNELS, 32'd0),
      req_row(FUNC_FILTER, 1'b0, 24'h5A_5A5A, 3'd0, COEF_B0, 32'd0, TYPED, 24'h5A_5A5A),
      // channel count above the channel limit
      cfg_row(ADDR_CHANNELS, 32'd3),
      req_row(FUNC_FILTER, 1'b1, 24'h12_3456, 3'd0, COEF_B0, 32'd0, PREDICTED, '0),
      // channel 1 outside the live range
      cfg_row(ADDR_CHANNELS, 32'd1),
      req_row(FUNC_FILTER, 1'b1, SMP_MAXV, 3'd0, COEF_B0, 32'd0, TYPED, SMP_MAXV),
      req_row(FUNC_FILTER, 1'b0, SMP_MINV, 3'd0, COEF_B0, 32'd0, PREDICTED, '0)
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        write_register(directed_plan[i].addr, directed_plan[i].wdata);
      end else begin
        send_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].out_val);
      end
    end

    // random phases: new setting, fresh coefficient set, clear, then a random mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(ADDR_STAGES, 32'(phase_stages[p]));
      write_register(ADDR_CHANNELS, 32'(phase_chans[p]));
      // one phase runs with no gaps and no stalls at all
      steady = (p == 2);
      for (int s = 0; s < MAX_ST; s++) begin
        for (int k = 0; k < NUM_COEF; k++) begin
          r = random_request();
          r.func  = FUNC_COEF;
          r.stage = 3'(s);
          r.sel   = 3'(k);
          r.cval  = pick_coef(r.sel);
          send_request(r, PREDICTED, '0);
        end
      end
      r = random_request();
      r.func = FUNC_CLEAR;
      send_request(r, PREDICTED, '0);
      for (int n = 0; n < per_phase - MAX_ST * NUM_COEF - 1; n++) begin
        send_request(random_request(), PREDICTED, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### biquad_cascade_filter.f
design/bqc_pkg.sv
design/bqc_cell.sv
design/biquad_cascade_filter.sv
design/bqc_chk.sv
dv/tb_biquad_cascade_filter.sv
